>>> sv/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants shared by the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int PARTITIONS        = 4;
	localparam int SEGMENTS_PER_PART = 16;
	localparam int SIZE_BITS         = 16;

	localparam int PART_BITS = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int SEG_BITS  = $clog2(SEGMENTS_PER_PART);
	localparam int CNT_BITS  = $clog2(SEGMENTS_PER_PART + 1);
	localparam int ADDR_BITS = PART_BITS + SEG_BITS;
	localparam int DEPTH     = PARTITIONS * SEGMENTS_PER_PART;
	localparam int ENTRY_W   = 3 * SIZE_BITS;

	localparam logic [2:0] CFG_PARTS  = 3'd0;
	localparam logic [2:0] CFG_SIZE_A = 3'd1;
	localparam logic [2:0] CFG_SIZE_D = 3'd4;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(4096);

	typedef struct packed {
		logic                 operation;
		logic [SIZE_BITS-1:0] alloc_size;
		logic [SIZE_BITS-1:0] owner_id;
	} req_t;

	typedef struct packed {
		logic                 ok;
		logic [2:0]           block_number;
		logic [SIZE_BITS-1:0] offset;
	} rsp_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] owner;
		logic [SIZE_BITS-1:0] first;
		logic [SIZE_BITS-1:0] last;
	} entry_t;

endpackage

>>> sv/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/first_fit_partition_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top
// First-fit allocator over fixed partitions; segment tables in one RAM.
// ----------------------------------------------------------------------------
// sequence: partitions are visited in turn, table entries are read, entries are
//   moved to open or close a gap, and the result is set on finish
// throughput: one request at a time; the next request is taken only after the
//   result has been accepted
// reset: tables empty, four partitions in use, each partition 4096 bytes
module first_fit_partition_allocator_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ffpa_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ffpa_pkg::rsp_t       rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import ffpa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PART  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_MVRD  = 3'd4;
	localparam logic [2:0] ST_MVWR  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]           state_q;
	logic [2:0]           parts_q;
	logic [SIZE_BITS-1:0] psize_q [PARTITIONS];
	logic [SIZE_BITS-1:0] free_q  [PARTITIONS];
	logic [CNT_BITS-1:0]  cnt_q   [PARTITIONS];
	req_t                 req_q;
	logic [PART_BITS:0]   p_q;
	logic [CNT_BITS-1:0]  k_q;
	logic [CNT_BITS-1:0]  j_q;
	logic [SIZE_BITS:0]   prev_q;     // prev_end + 1
	logic [SIZE_BITS-1:0] start_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic                 we;
	logic [ADDR_BITS-1:0] waddr, raddr;
	entry_t               wdata, rdata, hold_q;
	logic [PART_BITS-1:0] pi;
	logic [2:0]           nparts;
	logic [SIZE_BITS:0]   limit;
	logic [CNT_BITS-1:0]  cnt;

	assign pi     = p_q[PART_BITS-1:0];
	assign cnt    = cnt_q[pi];
	assign nparts = (parts_q > 3'(PARTITIONS)) ? 3'(PARTITIONS) : parts_q;
	assign limit  = (k_q < cnt) ? {1'b0, rdata.first} : {1'b0, psize_q[pi]};

	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;
	assign cfg_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ffpa_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_seg_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// read address follows the current scan or move index
	always_comb begin
		raddr = {pi, k_q[SEG_BITS-1:0]};
		if (state_q == ST_MVRD) begin
			raddr = {pi, j_q[SEG_BITS-1:0]};
		end
	end

	// allocation copies entry j up to j+1; release copies entry j down to j-1
	always_comb begin
		we    = 1'b0;
		waddr = {pi, j_q[SEG_BITS-1:0]};
		wdata = rdata;
		if (state_q == ST_MVWR) begin
			we = 1'b1;
			if (req_q.operation == OP_ALLOC) begin
				waddr = {pi, SEG_BITS'(j_q + 1'b1)};
			end else begin
				waddr = {pi, SEG_BITS'(j_q - 1'b1)};
			end
		end else if (state_q == ST_FIN && req_q.operation == OP_ALLOC) begin
			we    = 1'b1;
			waddr = {pi, k_q[SEG_BITS-1:0]};
			wdata.owner = req_q.owner_id;
			wdata.first = start_q;
			wdata.last  = SIZE_BITS'(start_q + req_q.alloc_size - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			parts_q     <= 3'd4;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < PARTITIONS; i++) begin
				psize_q[i] <= (i < 4) ? SIZE_RESET : '0;
				free_q[i]  <= (i < 4) ? SIZE_RESET : '0;
				cnt_q[i]   <= '0;
			end
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_PARTS) begin
							parts_q <= cfg_data[2:0];
						end else if (cfg_index >= CFG_SIZE_A && cfg_index <= CFG_SIZE_D) begin
							for (int i = 0; i < PARTITIONS; i++) begin
								if (32'(cfg_index) - 1 == i) begin
									psize_q[i] <= cfg_data;
									free_q[i]  <= cfg_data;
									cnt_q[i]   <= '0;
								end
							end
						end
					end
					if (req_valid && !req_stall) begin
						req_q   <= req;
						p_q     <= '0;
						k_q     <= '0;
						prev_q  <= '0;
						rsp_q   <= '0;
						state_q <= ST_PART;
					end
				end
				ST_PART: begin
					k_q    <= '0;
					prev_q <= '0;
					if (p_q >= (PART_BITS+1)'(nparts) ||
					    (req_q.operation == OP_ALLOC && req_q.alloc_size == '0)) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (req_q.operation == OP_ALLOC &&
					             free_q[pi] < req_q.alloc_size) begin
						p_q <= p_q + 1'b1;
					end else if (req_q.operation == OP_RELEASE && cnt == '0) begin
						p_q <= p_q + 1'b1;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (req_q.operation == OP_ALLOC) begin
						if (limit >= prev_q && limit - prev_q >= {1'b0, req_q.alloc_size}) begin
							if (cnt >= CNT_BITS'(SEGMENTS_PER_PART)) begin
								rsp_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
							end else begin
								start_q <= prev_q[SIZE_BITS-1:0];
								j_q     <= cnt - 1'b1;
								state_q <= (cnt > k_q) ? ST_MVRD : ST_FIN;
							end
						end else if (k_q < cnt) begin
							prev_q  <= {1'b0, rdata.last} + 1'b1;
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= ST_PART;
						end
					end else begin
						if (rdata.owner == req_q.owner_id) begin
							hold_q  <= rdata;
							j_q     <= k_q + 1'b1;
							state_q <= (k_q + 1'b1 < cnt) ? ST_MVRD : ST_FIN;
						end else if (k_q + 1'b1 < cnt) begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= ST_PART;
						end
					end
				end
				ST_MVRD: begin
					state_q <= ST_MVWR;
				end
				ST_MVWR: begin
					if (req_q.operation == OP_ALLOC) begin
						if (j_q == k_q) begin
							state_q <= ST_FIN;
						end else begin
							j_q     <= j_q - 1'b1;
							state_q <= ST_MVRD;
						end
					end else begin
						// write landed at j-1; move to next source
						if (j_q + 1'b1 >= cnt) begin
							state_q <= ST_FIN;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_MVRD;
						end
					end
				end
				ST_FIN: begin
					rsp_q.ok           <= 1'b1;
					rsp_q.block_number <= 3'(p_q + 1'b1);
					rsp_valid_q        <= 1'b1;
					state_q            <= ST_IDLE;
					if (req_q.operation == OP_ALLOC) begin
						rsp_q.offset <= start_q;
						cnt_q[pi]    <= cnt + 1'b1;
						free_q[pi]   <= free_q[pi] - req_q.alloc_size;
					end else begin
						rsp_q.offset <= hold_q.first;
						cnt_q[pi]    <= cnt - 1'b1;
						free_q[pi]   <= SIZE_BITS'(free_q[pi] + hold_q.last - hold_q.first + 1'b1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_req_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("request taken while busy");
	a_rsp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("result dropped while stalled");
	a_write_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_MVWR || state_q == ST_FIN))
		else $error("table write outside move or finish");
	a_fin_sets_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (rsp_valid && rsp.ok))
		else $error("finish without result");
`endif
endmodule
